### hw/rtl/tspg_pkg.sv
// tspg_pkg: shared types and constants of the trapezoid step pulse generator
// no dependencies; imported by tspg_dp, tspg_ctrl, the top module and the testbench
`timescale 1ns / 1ps

package tspg_pkg;

  localparam int COUNT_BITS   = 24;
  localparam int EDGE_W       = COUNT_BITS + 1;
  localparam int PERIOD_W     = 16;
  localparam int CFG_AW       = 4;
  localparam int CFG_DW       = 32;
  // accel_step must exceed 1/10000 of one tick for a ramp to be planned
  localparam int RAMP_EPS_INV = 10000;
  localparam int EPS_PROD_W   = 30;

  localparam logic [15:0] MIN_PERIOD_RST = 16'd2;
  localparam logic [15:0] MAX_PERIOD_RST = 16'd10;
  localparam logic [15:0] ACCEL_RST      = 16'd328;

  localparam logic [1:0] REG_MIN_PERIOD = 2'd0;
  localparam logic [1:0] REG_MAX_PERIOD = 2'd1;
  localparam logic [1:0] REG_ACCEL_STEP = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2
  } tspg_op_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ACCEL  = 2'd1,
    PH_CRUISE = 2'd2,
    PH_DECEL  = 2'd3
  } tspg_phase_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_DIV  = 2'd2,
    S_PLAN = 2'd3
  } tspg_state_t;

  typedef struct packed {
    tspg_op_t              op;
    logic [COUNT_BITS-1:0] step_count;
    logic                  direction;
  } tspg_in_t;

  typedef struct packed {
    logic        step_level;
    logic        dir_level;
    logic        busy_res;
    tspg_phase_t phase;
    logic        move_done;
    logic        rejected;
  } tspg_out_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic div_start;
    logic apply;
  } tspg_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_done;
  } tspg_sts_t;

endpackage

### hw/rtl/tspg_div.sv
// tspg_div: bit-serial restoring divider, one quotient bit per cycle
// depends on nothing but its parameters
`timescale 1ns / 1ps

module tspg_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W:0]   trial;
  logic             fits;
  logic             last;

  assign trial = {rem_r, q_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};
  assign last  = cnt_r == CNT_W'(NUM_W - 1);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      q_nxt    = num;
    end else if (busy_r) begin
      // remainder stays below den, so the low DEN_W bits carry it
      rem_nxt = fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      q_nxt   = {q_r[NUM_W-2:0], fits};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

### hw/rtl/tspg_dp.sv
// tspg_dp: move state, planning and per-tick period update, result register
// depends on tspg_pkg and tspg_div
`timescale 1ns / 1ps

module tspg_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tspg_pkg::tspg_in_t  in_data,
  input  logic [15:0]         min_period,
  input  logic [15:0]         max_period,
  input  logic [15:0]         accel_step,
  input  tspg_pkg::tspg_cmd_t cmd,
  output tspg_pkg::tspg_sts_t sts,
  output tspg_pkg::tspg_out_t out_data
);

  import tspg_pkg::*;

  localparam int SPD_W = PERIOD_W + FRAC_BITS;
  localparam int NUM_W = PERIOD_W + FRAC_BITS;
  localparam int SAT_W = (NUM_W > EDGE_W) ? NUM_W : EDGE_W;
  localparam int SUM_W = SPD_W + 2;

  tspg_in_t          item_r;
  tspg_out_t         out_r, out_nxt;
  logic [SPD_W-1:0]  speed_r, speed_nxt;
  logic [15:0]       cd_r, cd_nxt;
  logic [EDGE_W-1:0] rem_r, rem_nxt;
  logic [EDGE_W-1:0] ramp_r, ramp_nxt;
  logic [EDGE_W-1:0] cruise_r, cruise_nxt;
  tspg_phase_t       phase_r, phase_nxt;
  logic              step_r, step_nxt;
  logic              dir_r, dir_nxt;
  logic              done_v, rej_v;

  logic [EPS_PROD_W-1:0] eps_prod;
  logic                  ramp_ok;
  logic                  div_done;
  logic [NUM_W-1:0]      quot;
  logic [SAT_W-1:0]      quot_ext;
  logic [EDGE_W-1:0]     ramp_sat;
  logic [EDGE_W-1:0]     ramp_sel;
  logic [EDGE_W-1:0]     total;
  logic [EDGE_W:0]       ramp2;
  logic                  short_move;
  logic [EDGE_W-1:0]     plan_ramp;
  logic [EDGE_W-1:0]     plan_cruise;

  logic signed [SUM_W-1:0] sum_s, lo_s, hi_s, clamp_s;
  logic [SUM_W-1:0]        speed_ext, accel_ext;
  logic [SPD_W-1:0]        speed_adj;

  // ramp planning
  assign eps_prod = EPS_PROD_W'(accel_step) * EPS_PROD_W'(RAMP_EPS_INV);
  assign ramp_ok  = (eps_prod > (EPS_PROD_W'(1) << FRAC_BITS)) && (max_period > min_period);

  tspg_div #(
    .NUM_W (NUM_W),
    .DEN_W (16)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   ({max_period - min_period, {FRAC_BITS{1'b0}}}),
    .den   (accel_step),
    .done  (div_done),
    .quot  (quot)
  );

  assign quot_ext    = SAT_W'(quot);
  assign ramp_sat    = (quot_ext > SAT_W'({EDGE_W{1'b1}})) ? {EDGE_W{1'b1}}
                                                           : quot_ext[EDGE_W-1:0];
  assign ramp_sel    = ramp_ok ? ramp_sat : '0;
  assign total       = {item_r.step_count, 1'b0};
  assign ramp2       = {ramp_sel, 1'b0};
  assign short_move  = {1'b0, total} <= ramp2;
  assign plan_ramp   = short_move ? EDGE_W'(item_r.step_count) : ramp_sel;
  assign plan_cruise = short_move ? '0 : EDGE_W'({1'b0, total} - ramp2);

  assign sts.need_div = (item_r.op == OP_START) && (phase_r == PH_IDLE) &&
                        (item_r.step_count != '0) && ramp_ok;
  assign sts.div_done = div_done;

  // period step and clamp, min first then max
  assign speed_ext = SUM_W'(speed_r);
  assign accel_ext = SUM_W'(accel_step);
  assign lo_s      = $signed({2'b00, min_period, {FRAC_BITS{1'b0}}});
  assign hi_s      = $signed({2'b00, max_period, {FRAC_BITS{1'b0}}});

  always_comb begin
    case (phase_r)
      PH_ACCEL: sum_s = $signed(speed_ext - accel_ext);
      PH_DECEL: sum_s = $signed(speed_ext + accel_ext);
      default:  sum_s = $signed(speed_ext);
    endcase
    if (sum_s < lo_s) begin
      clamp_s = lo_s;
    end else if (sum_s > hi_s) begin
      clamp_s = hi_s;
    end else begin
      clamp_s = sum_s;
    end
  end

  assign speed_adj = clamp_s[SPD_W-1:0];

  always_comb begin
    speed_nxt  = speed_r;
    cd_nxt     = cd_r;
    rem_nxt    = rem_r;
    ramp_nxt   = ramp_r;
    cruise_nxt = cruise_r;
    phase_nxt  = phase_r;
    step_nxt   = step_r;
    dir_nxt    = dir_r;
    done_v     = 1'b0;
    rej_v      = 1'b0;
    if (cmd.apply) begin
      case (item_r.op)
        OP_START: begin
          if (phase_r != PH_IDLE) begin
            rej_v = 1'b1;
          end else if (item_r.step_count == '0) begin
            done_v = 1'b1;
          end else begin
            dir_nxt    = item_r.direction;
            ramp_nxt   = plan_ramp;
            cruise_nxt = plan_cruise;
            speed_nxt  = {max_period, {FRAC_BITS{1'b0}}};
            phase_nxt  = PH_ACCEL;
            rem_nxt    = plan_ramp;
            cd_nxt     = max_period;
          end
        end
        OP_STOP: begin
          phase_nxt  = PH_IDLE;
          cd_nxt     = '0;
          rem_nxt    = '0;
          ramp_nxt   = '0;
          cruise_nxt = '0;
        end
        OP_TICK: begin
          if (phase_r != PH_IDLE) begin
            if (cd_r != '0) begin
              cd_nxt = cd_r - 16'd1;
            end else if (rem_r != '0) begin
              rem_nxt   = rem_r - EDGE_W'(1);
              speed_nxt = speed_adj;
              step_nxt  = ~step_r;
              cd_nxt    = speed_adj[SPD_W-1 -: PERIOD_W];
            end else begin
              // extra expiry closes the phase and loads the next one, or ends the move after deceleration
              cd_nxt = speed_r[SPD_W-1 -: PERIOD_W];
              case (phase_r)
                PH_ACCEL: begin
                  if (cruise_r != '0) begin
                    phase_nxt = PH_CRUISE;
                    rem_nxt   = cruise_r;
                  end else begin
                    phase_nxt = PH_DECEL;
                    rem_nxt   = ramp_r;
                  end
                end
                PH_CRUISE: begin
                  phase_nxt = PH_DECEL;
                  rem_nxt   = ramp_r;
                end
                default: begin
                  phase_nxt = PH_IDLE;
                  done_v    = 1'b1;
                end
              endcase
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_nxt = out_r;
    if (cmd.apply) begin
      out_nxt.step_level = step_nxt;
      out_nxt.dir_level  = dir_nxt;
      out_nxt.busy_res   = phase_nxt != PH_IDLE;
      out_nxt.phase      = phase_nxt;
      out_nxt.move_done  = done_v;
      out_nxt.rejected   = rej_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r  <= '0;
      cd_r     <= '0;
      rem_r    <= '0;
      ramp_r   <= '0;
      cruise_r <= '0;
      phase_r  <= PH_IDLE;
      step_r   <= 1'b0;
      dir_r    <= 1'b0;
    end else begin
      speed_r  <= speed_nxt;
      cd_r     <= cd_nxt;
      rem_r    <= rem_nxt;
      ramp_r   <= ramp_nxt;
      cruise_r <= cruise_nxt;
      phase_r  <= phase_nxt;
      step_r   <= step_nxt;
      dir_r    <= dir_nxt;
    end
    if (cmd.latch) begin
      item_r <= in_data;
    end
    out_r <= out_nxt;
  end

  assign out_data = out_r;

endmodule

### hw/rtl/tspg_ctrl.sv
// tspg_ctrl: request sequencing, divider launch and result register control
// depends on tspg_pkg
`timescale 1ns / 1ps

module tspg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  tspg_pkg::tspg_sts_t sts,
  output tspg_pkg::tspg_cmd_t cmd
);

  import tspg_pkg::*;

  tspg_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.need_div) begin
          state_nxt = S_DIV;
        end else if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_PLAN;
        end
      end
      S_PLAN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.latch     = 1'b0;
    cmd.div_start = 1'b0;
    cmd.apply     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      S_EXEC: begin
        cmd.div_start = sts.need_div;
        cmd.apply     = !sts.need_div && out_free;
      end
      S_PLAN: begin
        cmd.apply = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.apply) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  // a result is never written over one that has not been taken
  a_apply_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == S_DIV))
    else $error("divider finished outside of division wait");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |=> (state_r == S_DIV || state_r == S_PLAN))
    else $error("division wait left without planning");

  a_apply_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |=> out_valid_r)
    else $error("applied request gave no result");
`endif

endmodule

### hw/rtl/trapezoid_step_pulse_generator.sv
// channel  | direction | handshake             | payload
// in       | input     | in_valid / in_ready   | in_data  (op, step_count, direction)
// out      | output    | out_valid / out_ready | out_data (pin levels, phase, flags)
// cfg      | apb       | psel/penable/pready   | paddr, pwdata, prdata
//
// tick and stop are latched on accept and applied to the output register from S_EXEC once it
// is free, as is a start without a ramp; a start with a ramp first waits in S_DIV for the
// bit-serial ramp divider, one quotient bit per cycle, and is applied from S_PLAN
// one request in flight; the next is accepted while a result waits in the output register
// synchronous active-low reset restores the register defaults and an idle motor
// depends on tspg_pkg, tspg_ctrl, tspg_dp
`timescale 1ns / 1ps

module trapezoid_step_pulse_generator #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  tspg_pkg::tspg_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output tspg_pkg::tspg_out_t               out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tspg_pkg::CFG_AW-1:0]       paddr,
  input  logic [tspg_pkg::CFG_DW-1:0]       pwdata,
  output logic [tspg_pkg::CFG_DW-1:0]       prdata,
  output logic                              pready
);

  import tspg_pkg::*;

  logic [15:0] min_period_r, min_period_nxt;
  logic [15:0] max_period_r, max_period_nxt;
  logic [15:0] accel_step_r, accel_step_nxt;
  logic        wr_en;
  logic [1:0]  reg_idx;
  tspg_cmd_t   cmd;
  tspg_sts_t   sts;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_comb begin
    min_period_nxt = min_period_r;
    max_period_nxt = max_period_r;
    accel_step_nxt = accel_step_r;
    if (wr_en) begin
      case (reg_idx)
        REG_MIN_PERIOD: min_period_nxt = pwdata[15:0];
        REG_MAX_PERIOD: max_period_nxt = pwdata[15:0];
        REG_ACCEL_STEP: accel_step_nxt = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MIN_PERIOD: prdata = CFG_DW'(min_period_r);
      REG_MAX_PERIOD: prdata = CFG_DW'(max_period_r);
      REG_ACCEL_STEP: prdata = CFG_DW'(accel_step_r);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_period_r <= MIN_PERIOD_RST;
      max_period_r <= MAX_PERIOD_RST;
      accel_step_r <= ACCEL_RST;
    end else begin
      min_period_r <= min_period_nxt;
      max_period_r <= max_period_nxt;
      accel_step_r <= accel_step_nxt;
    end
  end

  tspg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tspg_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .min_period (min_period_r),
    .max_period (max_period_r),
    .accel_step (accel_step_r),
    .cmd        (cmd),
    .sts        (sts),
    .out_data   (out_data)
  );

endmodule

### dv/testbench.sv
// testbench: self-checking regression for the trapezoid step pulse generator
// predicts pin levels, phase and flags per request; depends on tspg_pkg and the block rtl
`timescale 1ns / 1ps

module testbench;
  import tspg_pkg::*;

  localparam int FRAC = 16;
  localparam int SETTLE_CYCLES = 40;
  localparam tspg_op_t OP_NONE = tspg_op_t'(2'd3);

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  tspg_in_t          in_data;
  logic              out_valid;
  logic              out_ready;
  tspg_out_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  trapezoid_step_pulse_generator u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // motor state as the predictor sees it
  logic [15:0]     min_per, max_per, accel_amt;
  logic [31:0]     edge_period;
  logic [15:0]     tick_count;
  logic [EDGE_W-1:0] edges_left, ramp_len, cruise_len;
  tspg_phase_t     motor_phase;
  logic            step_pin_q, dir_pin_q;

  tspg_out_t pending_pin_states[$];
  tspg_out_t got_res, want_res;

  int gap_pct, stall_pct;
  int errors, results_checked, moves_done, starts_refused;
  int n_ticks, n_starts, n_stops, n_other, phase_reqs;

  always #2 clk = ~clk;

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (errors < 30)
      $display("mismatch at %0t ns: %s got %0h expected %0h", $time, what, got, want);
    errors++;
  endtask

  function automatic void enter_phase(tspg_phase_t p, logic [EDGE_W-1:0] n);
    motor_phase = p;
    edges_left  = n;
    tick_count  = edge_period[31:16];
  endfunction

  // clamp: raise to min first, else lower to max
  function automatic void nudge_period(longint delta);
    longint lo, hi, v;
    lo = longint'(min_per) << FRAC;
    hi = longint'(max_per) << FRAC;
    v  = longint'(edge_period) + delta;
    if (v < lo) v = lo;
    else if (v > hi) v = hi;
    edge_period = v[31:0];
  endfunction

  function automatic tspg_out_t predict_pins(tspg_in_t r);
    tspg_out_t e;
    longint unsigned ramp, total;
    logic done, rej;
    done = 1'b0;
    rej  = 1'b0;
    case (r.op)
      OP_START: begin
        if (motor_phase != PH_IDLE) begin
          rej = 1'b1;
        end else if (r.step_count == 0) begin
          done = 1'b1;
        end else begin
          total = longint'(r.step_count) * 2;
          ramp  = 0;
          dir_pin_q = r.direction;
          if (longint'(accel_amt) * RAMP_EPS_INV > (longint'(1) << FRAC) && max_per > min_per)
          begin
            ramp = (longint'(max_per - min_per) << FRAC) / accel_amt;
            if (ramp > (longint'(1) << EDGE_W) - 1) ramp = (longint'(1) << EDGE_W) - 1;
          end
          if (total <= ramp * 2) begin
            ramp_len   = EDGE_W'(total / 2);
            cruise_len = '0;
          end else begin
            ramp_len   = EDGE_W'(ramp);
            cruise_len = EDGE_W'(total - 2 * ramp);
          end
          edge_period = {max_per, 16'h0};
          enter_phase(PH_ACCEL, ramp_len);
        end
      end
      OP_STOP: begin
        motor_phase = PH_IDLE;
        tick_count  = '0;
        edges_left  = '0;
        ramp_len    = '0;
        cruise_len  = '0;
      end
      OP_TICK: begin
        if (motor_phase != PH_IDLE) begin
          if (tick_count != 0) begin
            tick_count--;
          end else if (edges_left != 0) begin
            edges_left--;
            if (motor_phase == PH_ACCEL) nudge_period(-longint'(accel_amt));
            else if (motor_phase == PH_DECEL) nudge_period(longint'(accel_amt));
            else nudge_period(0);
            step_pin_q  = ~step_pin_q;
            tick_count  = edge_period[31:16];
          end else if (motor_phase == PH_ACCEL) begin
            if (cruise_len != 0) enter_phase(PH_CRUISE, cruise_len);
            else enter_phase(PH_DECEL, ramp_len);
          end else if (motor_phase == PH_CRUISE) begin
            enter_phase(PH_DECEL, ramp_len);
          end else begin
            motor_phase = PH_IDLE;
            tick_count  = edge_period[31:16];
            done = 1'b1;
          end
        end
      end
      default: ;
    endcase
    e.step_level = step_pin_q;
    e.dir_level  = dir_pin_q;
    e.busy_res   = (motor_phase != PH_IDLE);
    e.phase      = motor_phase;
    e.move_done  = done;
    e.rejected   = rej;
    return e;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_res = out_data;
      if (pending_pin_states.size() == 0) begin
        report_mismatch("result with no request pending", 32'(got_res), 32'd0);
      end else begin
        want_res = pending_pin_states.pop_front();
        if (got_res.step_level !== want_res.step_level)
          report_mismatch("step_level", 32'(got_res.step_level), 32'(want_res.step_level));
        if (got_res.dir_level !== want_res.dir_level)
          report_mismatch("dir_level", 32'(got_res.dir_level), 32'(want_res.dir_level));
        if (got_res.busy_res !== want_res.busy_res)
          report_mismatch("busy_res", 32'(got_res.busy_res), 32'(want_res.busy_res));
        if (got_res.phase !== want_res.phase)
          report_mismatch("phase", 32'(got_res.phase), 32'(want_res.phase));
        if (got_res.move_done !== want_res.move_done)
          report_mismatch("move_done", 32'(got_res.move_done), 32'(want_res.move_done));
        if (got_res.rejected !== want_res.rejected)
          report_mismatch("rejected", 32'(got_res.rejected), 32'(want_res.rejected));
        results_checked++;
        moves_done     += want_res.move_done;
        starts_refused += want_res.rejected;
      end
    end
  end

  // valid stays up across back-to-back requests; only a gap or wait_drained lowers it
  task automatic send_req(tspg_op_t op, logic [COUNT_BITS-1:0] n, logic d);
    tspg_in_t r;
    r.op = op;
    r.step_count = n;
    r.direction = d;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_pin_states.push_back(predict_pins(r));
    phase_reqs++;
    case (op)
      OP_TICK:  n_ticks++;
      OP_START: n_starts++;
      OP_STOP:  n_stops++;
      default:  n_other++;
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_pin_states.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write then read back one register
  task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {16'h0, val}) report_mismatch("register readback", prdata, {16'h0, val});
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_MIN_PERIOD: min_per = val;
      REG_MAX_PERIOD: max_per = val;
      default:        accel_amt = val;
    endcase
  endtask

  task automatic set_profile(logic [15:0] lo, logic [15:0] hi, logic [15:0] acc);
    cfg_write(REG_MIN_PERIOD, lo);
    cfg_write(REG_MAX_PERIOD, hi);
    cfg_write(REG_ACCEL_STEP, acc);
  endtask

  task automatic test_idle_requests();
    send_req(OP_TICK, '0, 1'b0);
    send_req(OP_NONE, '1, 1'b1);
    send_req(OP_START, '0, 1'b1);
    send_req(OP_STOP, '0, 1'b0);
  endtask

  task automatic test_default_ramp();
    send_req(OP_START, 24'd1, 1'b1);
    send_req(OP_START, '1, 1'b0);
    send_req(OP_TICK, '0, 1'b0);
    send_req(OP_STOP, '0, 1'b0);
  endtask

  // zero-length ramp: each ramp phase still burns one expiry
  task automatic test_no_ramp_move();
    set_profile(16'd1, 16'd1, 16'd0);
    send_req(OP_START, 24'd1, 1'b0);
    while (motor_phase != PH_IDLE) send_req(OP_TICK, '0, 1'b0);
  endtask

  task automatic test_clamp_order();
    set_profile(16'hFFFF, 16'd1, 16'hFFFF);
    send_req(OP_START, '1, 1'b1);
    repeat (4) send_req(OP_TICK, '1, 1'b1);
    send_req(OP_STOP, '0, 1'b0);
  endtask

  task automatic test_wide_range();
    set_profile(16'd1, 16'hFFFF, 16'hFFFF);
    send_req(OP_START, 24'd3, 1'b0);
    send_req(OP_TICK, '0, 1'b0);
    send_req(OP_STOP, '0, 1'b1);
  endtask

  task automatic run_move();
    int abort_at, guard, pick;
    if (motor_phase != PH_IDLE) send_req(OP_STOP, COUNT_BITS'($urandom), 1'($urandom));
    send_req(OP_START, COUNT_BITS'($urandom_range(8)), 1'($urandom));
    abort_at = ($urandom_range(99) < 10) ? $urandom_range(1, 20) : -1;
    guard = 0;
    while (motor_phase != PH_IDLE && guard < 400) begin
      pick = $urandom_range(99);
      if (guard == abort_at) send_req(OP_STOP, COUNT_BITS'($urandom), 1'($urandom));
      else if (pick < 4) send_req(OP_START, COUNT_BITS'($urandom), 1'($urandom));
      else if (pick < 6) send_req(OP_NONE, COUNT_BITS'($urandom), 1'($urandom));
      else send_req(OP_TICK, COUNT_BITS'($urandom), 1'($urandom));
      guard++;
    end
    if (motor_phase != PH_IDLE) send_req(OP_STOP, '0, 1'b0);
  endtask

  task automatic test_random_traffic(int budget, logic [15:0] lo, logic [15:0] hi,
                                     logic [15:0] acc, int gap, int stall);
    int pick;
    set_profile(lo, hi, acc);
    gap_pct    = gap;
    stall_pct  = stall;
    phase_reqs = 0;
    while (phase_reqs < budget) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        run_move();
      end else if (pick < 85) begin
        // long move, cut short
        send_req(OP_START, COUNT_BITS'($urandom), 1'($urandom));
        repeat ($urandom_range(10)) send_req(OP_TICK, COUNT_BITS'($urandom), 1'($urandom));
        send_req(OP_STOP, COUNT_BITS'($urandom), 1'($urandom));
      end else begin
        send_req(tspg_op_t'($urandom_range(3)), COUNT_BITS'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    #2_000_000;
    $display("trapezoid_step_pulse_generator regression: fail");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    gap_pct = 30;
    stall_pct = 30;
    errors = 0;
    results_checked = 0;
    moves_done = 0;
    starts_refused = 0;
    n_ticks = 0;
    n_starts = 0;
    n_stops = 0;
    n_other = 0;
    phase_reqs = 0;
    min_per = MIN_PERIOD_RST;
    max_per = MAX_PERIOD_RST;
    accel_amt = ACCEL_RST;
    edge_period = '0;
    tick_count = '0;
    edges_left = '0;
    ramp_len = '0;
    cruise_len = '0;
    motor_phase = PH_IDLE;
    step_pin_q = 1'b0;
    dir_pin_q = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_requests();
    test_default_ramp();
    test_no_ramp_move();
    test_clamp_order();
    test_wide_range();

    test_random_traffic(200, 16'd1, 16'd3, 16'hFFFF, 0, 0);
    test_random_traffic(200, 16'd1, 16'd2, 16'd7, 61, 0);
    test_random_traffic(200, 16'd1, 16'd1, 16'd0, 0, 61);
    test_random_traffic(200, 16'd3, 16'd2, 16'd6, 38, 38);
    wait_drained();

    $display("covered %0d requests: %0d starts, %0d ticks, %0d stops, %0d ignored ops",
             n_ticks + n_starts + n_stops + n_other, n_starts, n_ticks, n_stops, n_other);
    $display("checked %0d results, %0d moves finished, %0d starts refused while busy",
             results_checked, moves_done, starts_refused);
    if (errors == 0) begin
      $display("trapezoid_step_pulse_generator regression: pass");
    end else begin
      $display("trapezoid_step_pulse_generator regression: fail");
    end
    $finish;
  end

endmodule

### trapezoid_step_pulse_generator.f
hw/rtl/tspg_pkg.sv
hw/rtl/tspg_div.sv
hw/rtl/tspg_dp.sv
hw/rtl/tspg_ctrl.sv
hw/rtl/trapezoid_step_pulse_generator.sv
dv/testbench.sv
